### hw/rtl/bre_pkg.sv
// Shared types and constants for the binary range encoder.
package bre_pkg;

    localparam logic KIND_ENCODE = 1'b0;
    localparam logic KIND_FINISH = 1'b1;

    localparam int unsigned RESULT_CAP   = 37;
    localparam int unsigned FINISH_SHIFTS = 5;

    typedef struct packed {
        logic        kind;
        logic        bit_value;
        logic [11:0] weight;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last;
        logic       pending_error;
    } t_out_item;

    typedef struct packed {
        logic        kind;
        logic [2:0]  n_shifts;
        logic        carry;
        logic [31:0] low;
    } t_job;

endpackage

### hw/rtl/bre_fifo.sv
// Small synchronous FIFO used for the job queue and the result queue.
module bre_fifo #(
    parameter type t_data = logic [7:0],
    parameter int  AW     = 1
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_data i_data,
    output logic  o_full,
    input  logic  i_pop,
    output t_data o_data,
    output logic  o_empty
);

    localparam int DEPTH = 2 ** AW;

    t_data          r_mem [DEPTH];
    logic [AW-1:0]  r_wp;
    logic [AW-1:0]  r_rp;
    logic [AW:0]    r_cnt;
    logic           wr_en;
    logic           rd_en;

    assign o_full  = (r_cnt == (AW+1)'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rp];
    assign wr_en   = i_push && !o_full;
    assign rd_en   = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr_en) begin
                r_wp <= r_wp + 1'b1;
            end
            if (rd_en) begin
                r_rp <= r_rp + 1'b1;
            end
            case ({wr_en, rd_en})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

### hw/rtl/bre_front.sv
// Front end: accepts items, splits the range, and queues output-shift jobs.
module bre_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  bre_pkg::t_in_item i_item,
    output logic              o_full,
    output logic              o_jq_push,
    output bre_pkg::t_job     o_job,
    input  logic              i_jq_full
);

    logic        r_busy;
    logic        r_kind;
    logic        r_bit;
    logic [31:0] r_thr;
    logic [31:0] r_range;
    logic [31:0] r_low;
    logic        r_carry;

    logic [11:0] w_eff;
    logic [31:0] thr_mul;
    logic        accept;
    logic        go;
    logic [32:0] sum;
    logic [31:0] nr;
    logic [31:0] nl;
    logic        cout;
    logic [1:0]  nsh;
    logic [31:0] range_next;
    logic [31:0] low_next;

    assign o_full = r_busy;
    assign accept = i_push && !r_busy;
    assign go     = r_busy && !i_jq_full;

    always_comb begin
        w_eff   = (i_item.weight == 12'd0) ? 12'd1 : i_item.weight;
        thr_mul = {12'd0, r_range[31:12]} * {20'd0, w_eff};

        sum = {1'b0, r_low} + {1'b0, r_thr};
        if (r_bit) begin
            nr   = r_range - r_thr;
            nl   = sum[31:0];
            cout = r_carry | sum[32];
        end else begin
            nr   = r_thr;
            nl   = r_low;
            cout = r_carry;
        end

        if (nr[31:16] == 16'd0) begin
            nsh = 2'd2;
        end else if (nr[31:24] == 8'd0) begin
            nsh = 2'd1;
        end else begin
            nsh = 2'd0;
        end

        case (nsh)
            2'd1: begin
                range_next = nr << 8;
                low_next   = nl << 8;
            end
            2'd2: begin
                range_next = nr << 16;
                low_next   = nl << 16;
            end
            default: begin
                range_next = nr;
                low_next   = nl;
            end
        endcase

        o_job = '0;
        if (r_kind == bre_pkg::KIND_FINISH) begin
            o_job.kind     = bre_pkg::KIND_FINISH;
            o_job.n_shifts = 3'(bre_pkg::FINISH_SHIFTS);
            o_job.carry    = r_carry;
            o_job.low      = r_low;
            o_jq_push      = go;
        end else begin
            o_job.kind     = bre_pkg::KIND_ENCODE;
            o_job.n_shifts = {1'b0, nsh};
            o_job.carry    = cout;
            o_job.low      = nl;
            o_jq_push      = go && (nsh != 2'd0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_range <= 32'hFFFF_FFFF;
            r_low   <= '0;
            r_carry <= 1'b0;
        end else begin
            if (accept) begin
                r_busy <= 1'b1;
                r_kind <= i_item.kind;
                r_bit  <= i_item.bit_value;
                r_thr  <= thr_mul;
            end
            if (go) begin
                r_busy <= 1'b0;
                if (r_kind == bre_pkg::KIND_FINISH) begin
                    r_range <= 32'hFFFF_FFFF;
                    r_low   <= '0;
                    r_carry <= 1'b0;
                end else begin
                    r_range <= range_next;
                    r_low   <= low_next;
                    r_carry <= (nsh != 2'd0) ? 1'b0 : cout;
                end
            end
        end
    end

endmodule

### hw/rtl/bre_back.sv
// Back end: byte cache, pending 0xFF run and carry resolution per shift job.
module bre_back #(
    parameter int MAX_PENDING = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_jq_empty,
    input  bre_pkg::t_job      i_job,
    output logic               o_jq_pop,
    output logic               o_oq_push,
    output bre_pkg::t_out_item o_res,
    input  logic               i_oq_full
);

    localparam int PW = 6;
    localparam int CW = 6;
    localparam int TW = 9;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EMIT
    } t_state;

    typedef enum logic {
        SUB_CACHE,
        SUB_PEND
    } t_sub;

    t_state         r_state;
    t_sub           r_sub;
    bre_pkg::t_job  r_job;
    logic [2:0]     r_si;
    logic [31:0]    r_low;
    logic           r_cv;
    logic [7:0]     r_cache;
    logic [PW-1:0]  r_pend;
    logic           r_err;
    logic           r_scv;
    logic [PW-1:0]  r_spend;
    logic           r_errf;
    logic [TW-1:0]  r_total;
    logic [CW-1:0]  r_cnt;

    logic [7:0]     top;
    logic           c;
    logic           hold;
    logic           last_shift;
    logic [TW-1:0]  cap_total;
    logic           emit_req;
    logic [7:0]     emit_val;
    logic           keep;
    logic           stall;

    always_comb begin
        top        = r_low[31:24];
        c          = (r_si == 3'd0) && r_job.carry;
        hold       = (top == 8'hFF) && !c;
        last_shift = (r_si == (r_job.n_shifts - 3'd1));
        cap_total  = (r_total > TW'(bre_pkg::RESULT_CAP)) ? TW'(bre_pkg::RESULT_CAP) : r_total;
        emit_req   = 1'b0;
        emit_val   = 8'hFF + {7'd0, c};
        if (r_state == ST_EMIT && !hold) begin
            if (r_sub == SUB_CACHE && r_cv) begin
                emit_req = 1'b1;
                emit_val = r_cache + {7'd0, c};
            end else if (r_sub == SUB_PEND && r_pend != '0) begin
                emit_req = 1'b1;
            end
        end
        keep      = (r_cnt < CW'(bre_pkg::RESULT_CAP));
        stall     = emit_req && keep && i_oq_full;
        o_oq_push = emit_req && keep && !i_oq_full;
        o_res.out_byte      = emit_val;
        o_res.last          = ({{(TW-CW){1'b0}}, r_cnt} == (cap_total - TW'(1)));
        o_res.pending_error = r_errf;
        o_jq_pop  = (r_state == ST_IDLE) && !i_jq_empty;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_sub   <= SUB_CACHE;
            r_cv    <= 1'b0;
            r_cache <= '0;
            r_pend  <= '0;
            r_err   <= 1'b0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (!i_jq_empty) begin
                        r_job   <= i_job;
                        r_low   <= i_job.low;
                        r_si    <= '0;
                        r_scv   <= r_cv;
                        r_spend <= r_pend;
                        r_errf  <= r_err;
                        r_total <= '0;
                        r_state <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    if (hold) begin
                        if (r_spend < PW'(MAX_PENDING)) begin
                            r_spend <= r_spend + 1'b1;
                        end else begin
                            r_errf <= 1'b1;
                        end
                    end else begin
                        r_total <= r_total + TW'(r_spend) + TW'(r_scv);
                        r_scv   <= 1'b1;
                        r_spend <= '0;
                    end
                    if (last_shift) begin
                        r_si    <= '0;
                        r_low   <= r_job.low;
                        r_sub   <= SUB_CACHE;
                        r_cnt   <= '0;
                        r_state <= ST_EMIT;
                    end else begin
                        r_low <= r_low << 8;
                        r_si  <= r_si + 3'd1;
                    end
                end
                ST_EMIT: begin
                    if (!stall) begin
                        if (emit_req && keep) begin
                            r_cnt <= r_cnt + 1'b1;
                        end
                        if (hold || (r_sub == SUB_PEND && r_pend == '0)) begin
                            if (hold) begin
                                if (r_pend < PW'(MAX_PENDING)) begin
                                    r_pend <= r_pend + 1'b1;
                                end else begin
                                    r_err <= 1'b1;
                                end
                            end else begin
                                r_cache <= top;
                                r_cv    <= 1'b1;
                                r_pend  <= '0;
                            end
                            r_sub <= SUB_CACHE;
                            r_low <= r_low << 8;
                            if (last_shift) begin
                                r_state <= ST_IDLE;
                                r_err   <= r_errf;
                                if (r_job.kind == bre_pkg::KIND_FINISH) begin
                                    r_cv    <= 1'b0;
                                    r_cache <= '0;
                                    r_pend  <= '0;
                                    r_err   <= 1'b0;
                                end
                            end else begin
                                r_si <= r_si + 3'd1;
                            end
                        end else if (r_sub == SUB_CACHE) begin
                            r_sub <= SUB_PEND;
                        end else begin
                            r_pend <= r_pend - 1'b1;
                        end
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

### hw/rtl/binary_range_encoder_core.sv
// Binary range encoder top level: front end, job queue, back end, result queue.
//
// An item occupies the front end first for the 20x12 split multiplier and then for
// the range/low update, which waits while the job queue is full, so full is high from
// each accepted item until its update is done. The back end works through each output-
// shift job (one or two shifts per bit, five for a finish) in two passes: a scan over
// the shifts to count the bytes and settle the error flag, then an emit pass over the
// shifts that, for each shift that releases bytes, checks the cached byte and then
// releases each pending 0xFF byte. The emit pass stalls while the result queue is full;
// long pending 0xFF runs dominate the back-end time.
module binary_range_encoder_core #(
    parameter int MAX_PENDING = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    input  bre_pkg::t_in_item  i_item,
    output logic               full,
    input  logic               pop,
    output bre_pkg::t_out_item o_result,
    output logic               empty
);

    logic               jq_push;
    logic               jq_full;
    logic               jq_pop;
    logic               jq_empty;
    bre_pkg::t_job      jq_in;
    bre_pkg::t_job      jq_out;
    logic               oq_push;
    logic               oq_full;
    bre_pkg::t_out_item oq_in;

    bre_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .i_item    (i_item),
        .o_full    (full),
        .o_jq_push (jq_push),
        .o_job     (jq_in),
        .i_jq_full (jq_full)
    );

    bre_fifo #(
        .t_data (bre_pkg::t_job),
        .AW     (1)
    ) u_jobq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (jq_push),
        .i_data  (jq_in),
        .o_full  (jq_full),
        .i_pop   (jq_pop),
        .o_data  (jq_out),
        .o_empty (jq_empty)
    );

    bre_back #(
        .MAX_PENDING (MAX_PENDING)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_jq_empty (jq_empty),
        .i_job      (jq_out),
        .o_jq_pop   (jq_pop),
        .o_oq_push  (oq_push),
        .o_res      (oq_in),
        .i_oq_full  (oq_full)
    );

    bre_fifo #(
        .t_data (bre_pkg::t_out_item),
        .AW     (2)
    ) u_resq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (oq_push),
        .i_data  (oq_in),
        .o_full  (oq_full),
        .i_pop   (pop),
        .o_data  (o_result),
        .o_empty (empty)
    );

endmodule
